FILE: rtl/lrfs_pkg.sv
// ----------------------------------------------------------------------------
// lrfs_pkg
// Shared widths, request codes and the command/divider records of the line
// rasterizer.
// ----------------------------------------------------------------------------
package lrfs_pkg;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 16;
	localparam int COLOR_BITS   = 16;
	localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 2;
	localparam int STEP_BITS    = FRAC_BITS + 2;
	localparam int QUO_BITS     = FRAC_BITS + 1;
	localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

	localparam logic [FRAC_BITS-1:0] HALF_PIX = {1'b1, {(FRAC_BITS-1){1'b0}}};

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_NEXT  = 1'b1
	} req_type_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0]        mag_t;

	typedef struct packed {
		logic                  is_start;
		logic                  y_major;
		logic                  step_neg;
		logic                  quo_neg;
		coord_t                maj_start;
		coord_t                min_start;
		coord_t                maj_stop;
		mag_t                  maj_mag;
		mag_t                  min_mag;
		logic [COLOR_BITS-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic start;
		mag_t divisor;
		mag_t numer;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [QUO_BITS-1:0] quo;
	} div_rsp_t;

endpackage

FILE: rtl/lrfs_ifs.sv
// ----------------------------------------------------------------------------
// lrfs_req_if / lrfs_pix_if
// Valid/ready channels for line requests and emitted pixels.
// ----------------------------------------------------------------------------
interface lrfs_req_if
	import lrfs_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	coord_t                x_start;
	coord_t                y_start;
	coord_t                x_end;
	coord_t                y_end;
	logic [COLOR_BITS-1:0] pen_color;

	modport source (
		output valid, req_type, x_start, y_start, x_end, y_end, pen_color,
		input  ready
	);
	modport sink (
		input  valid, req_type, x_start, y_start, x_end, y_end, pen_color,
		output ready
	);
endinterface

interface lrfs_pix_if
	import lrfs_pkg::*;
();
	logic                  valid;
	logic                  ready;
	coord_t                pixel_x;
	coord_t                pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);
endinterface

FILE: rtl/lrfs_front.sv
// ----------------------------------------------------------------------------
// lrfs_front
// Request intake: derives major axis, direction, deltas and quotient sign for
// start requests and queues every request in a two-entry command queue.
// ----------------------------------------------------------------------------
module lrfs_front
	import lrfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lrfs_req_if.sink   req,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	logic signed [COORD_BITS:0] dx, dy, dmaj, dmin;
	logic [COORD_BITS:0]        adx_w, ady_w;
	mag_t                       adx, ady;
	logic                       y_major;
	logic                       push;
	cmd_t                       cmd_in;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_comb begin
		dx      = {req.x_end[COORD_BITS-1], req.x_end} - {req.x_start[COORD_BITS-1], req.x_start};
		dy      = {req.y_end[COORD_BITS-1], req.y_end} - {req.y_start[COORD_BITS-1], req.y_start};
		adx_w   = dx[COORD_BITS] ? -dx : dx;
		ady_w   = dy[COORD_BITS] ? -dy : dy;
		adx     = adx_w[COORD_BITS-1:0];
		ady     = ady_w[COORD_BITS-1:0];
		y_major = ady > adx;
		dmaj    = y_major ? dy : dx;
		dmin    = y_major ? dx : dy;

		cmd_in.is_start  = req.req_type == REQ_START;
		cmd_in.y_major   = y_major;
		cmd_in.step_neg  = dmaj[COORD_BITS] || (dmaj == '0);
		cmd_in.quo_neg   = dmaj[COORD_BITS] ^ dmin[COORD_BITS];
		cmd_in.maj_start = y_major ? req.y_start : req.x_start;
		cmd_in.min_start = y_major ? req.x_start : req.y_start;
		cmd_in.maj_stop  = y_major ? req.y_end : req.x_end;
		cmd_in.maj_mag   = y_major ? ady : adx;
		cmd_in.min_mag   = y_major ? adx : ady;
		cmd_in.color     = req.pen_color;
	end

	assign req.ready = count_q != 2'd2;
	assign push      = req.valid && req.ready;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/lrfs_div.sv
// ----------------------------------------------------------------------------
// lrfs_div
// Restoring divider, one quotient bit per cycle: (numer << FRAC_BITS) / divisor.
// ----------------------------------------------------------------------------
module lrfs_div
	import lrfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t dreq,
	output div_rsp_t drsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	mag_t                    rem_q;
	mag_t                    dsr_q;
	logic [DIV_BITS-1:0]     dvd_q;

	logic [COORD_BITS:0] rem_sh;
	logic [COORD_BITS:0] rem_nx;
	logic                fits;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_BITS-1]};
		fits   = rem_sh >= {1'b0, dsr_q};
		rem_nx = fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			dvd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dsr_q  <= dreq.divisor;
				dvd_q  <= {dreq.numer, {FRAC_BITS{1'b0}}};
			end else if (busy_q) begin
				rem_q <= rem_nx[COORD_BITS-1:0];
				dvd_q <= {dvd_q[DIV_BITS-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign drsp.done = done_q;
	assign drsp.quo  = dvd_q[QUO_BITS-1:0];

endmodule

FILE: rtl/lrfs_back.sv
// ----------------------------------------------------------------------------
// lrfs_back
// Line walker: takes queued commands, sets up the fixed-point step through
// the divider and emits pixels into a registered output stage.
// ----------------------------------------------------------------------------
module lrfs_back
	import lrfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output div_req_t   dreq,
	input  div_rsp_t   drsp,
	lrfs_pix_if.source pix
);

	typedef enum logic [1:0] {
		S_CMD,
		S_DIVIDE,
		S_FIRST
	} state_t;

	state_t                    state_q;
	coord_t                    major_pos_q;
	coord_t                    major_stop_q;
	logic [ACC_BITS-1:0]       acc_q;
	logic [STEP_BITS-1:0]      step_q;
	logic                      y_major_q;
	logic                      step_neg_q;
	logic                      quo_neg_q;
	logic                      active_q;
	logic [COLOR_BITS-1:0]     held_color_q;
	logic                      out_valid_q;
	coord_t                    px_q;
	coord_t                    py_q;
	logic [COLOR_BITS-1:0]     pcolor_q;
	logic                      plast_q;

	logic                 out_free;
	logic                 take_start;
	logic                 take_next;
	logic                 emit_go;
	logic                 last_w;
	coord_t               minor_w;
	logic [ACC_BITS-1:0]  step_ext;
	logic [STEP_BITS-1:0] quo_ext;
	logic [STEP_BITS-1:0] step_div;
	logic [ACC_BITS-1:0]  acc_init;

	always_comb begin
		out_free   = !out_valid_q || pix.ready;
		take_start = (state_q == S_CMD) && cmd_valid && cmd.is_start;
		take_next  = (state_q == S_CMD) && cmd_valid && !cmd.is_start
			&& (!active_q || out_free);
		cmd_pop    = take_start || take_next;
		emit_go    = (take_next && active_q) || ((state_q == S_FIRST) && out_free);

		dreq.start   = take_start && (cmd.maj_mag != '0);
		dreq.divisor = cmd.maj_mag;
		dreq.numer   = cmd.min_mag;

		minor_w  = acc_q[FRAC_BITS +: COORD_BITS];
		last_w   = major_pos_q == major_stop_q;
		step_ext = {{(ACC_BITS-STEP_BITS){step_q[STEP_BITS-1]}}, step_q};
		quo_ext  = {1'b0, drsp.quo};
		step_div = quo_neg_q ? -quo_ext : quo_ext;
		acc_init = {{(ACC_BITS-FRAC_BITS-COORD_BITS){cmd.min_start[COORD_BITS-1]}},
			cmd.min_start, HALF_PIX};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CMD;
			major_pos_q  <= '0;
			major_stop_q <= '0;
			acc_q        <= '0;
			step_q       <= '0;
			y_major_q    <= 1'b0;
			step_neg_q   <= 1'b0;
			quo_neg_q    <= 1'b0;
			active_q     <= 1'b0;
			held_color_q <= '0;
			out_valid_q  <= 1'b0;
			px_q         <= '0;
			py_q         <= '0;
			pcolor_q     <= '0;
			plast_q      <= 1'b0;
		end else begin
			// emit current pixel and, unless it is the last, advance along the major axis
			if (emit_go) begin
				out_valid_q <= 1'b1;
				px_q        <= y_major_q ? minor_w : major_pos_q;
				py_q        <= y_major_q ? major_pos_q : minor_w;
				pcolor_q    <= held_color_q;
				plast_q     <= last_w;
				if (last_w) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					if (step_neg_q) begin
						major_pos_q <= major_pos_q - 1'b1;
						acc_q       <= acc_q - step_ext;
					end else begin
						major_pos_q <= major_pos_q + 1'b1;
						acc_q       <= acc_q + step_ext;
					end
				end
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CMD: begin
					if (take_start) begin
						major_pos_q  <= cmd.maj_start;
						major_stop_q <= cmd.maj_stop;
						acc_q        <= acc_init;
						step_q       <= '0;
						y_major_q    <= cmd.y_major;
						step_neg_q   <= cmd.step_neg;
						quo_neg_q    <= cmd.quo_neg;
						held_color_q <= cmd.color;
						active_q     <= 1'b0;
						state_q      <= dreq.start ? S_DIVIDE : S_FIRST;
					end
				end
				S_DIVIDE: begin
					if (drsp.done) begin
						step_q  <= step_div;
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					if (out_free) begin
						state_q <= S_CMD;
					end
				end
				default: state_q <= S_CMD;
			endcase
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = px_q;
	assign pix.pixel_y     = py_q;
	assign pix.pixel_color = pcolor_q;
	assign pix.last_pixel  = plast_q;

	a_no_pop_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVIDE) |-> !cmd_pop)
		else $error("command taken during step setup");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_DIVIDE))
		else $error("divider finished outside setup");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_w) |=> !active_q)
		else $error("line still active after last pixel");

endmodule

FILE: rtl/line_rasterizer_fixed_step.sv
// ----------------------------------------------------------------------------
// line_rasterizer_fixed_step
// Line rasterizer with a signed 2.16 fixed-point minor-axis step.
// ----------------------------------------------------------------------------
// Channels: req (sink) takes start and next requests; pix (source) returns
// one pixel per start request and per next request of an active line.
// A next request while no line is active is dropped with no pixel.
// Requests pass through a two-entry queue into the line walker.
// Path: a next request passes through the queue and the output register; a
// start request also waits for the bit-serial step divider (28 quotient
// bits, one per cycle), which a line of one pixel skips. During a line,
// pixels follow one per cycle if next requests arrive and pix.ready is high.
// Up to two requests are taken while the divider runs, then req.ready drops.
// A stalled pix.ready holds the pixel in the output register; the walker
// waits and the queue fills, after which req.ready drops.
// Reset empties the queue, ends any line and clears the output register.
// ----------------------------------------------------------------------------
module line_rasterizer_fixed_step
	import lrfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lrfs_req_if.sink   req,
	lrfs_pix_if.source pix
);

	logic     cmd_valid;
	logic     cmd_pop;
	cmd_t     cmd;
	div_req_t dreq;
	div_rsp_t drsp;

	lrfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	lrfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	lrfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.dreq      (dreq),
		.drsp      (drsp),
		.pix       (pix)
	);

endmodule
